### rtl/core/escd_pkg.sv
// Shared constants, register codes and curve helpers for the exponential soft-clip block.
`timescale 1ns / 1ps

package escd_pkg;

  // Default build parameters
  localparam int SAMPLE_BITS_DEFAULT         = 16;
  localparam int CURVE_TABLE_ENTRIES_DEFAULT = 256;

  // Configuration port
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DRIVE_GAIN = 4'd0,
    CFG_WET_MIX    = 4'd1
  } cfg_reg_e;

  localparam logic [7:0]  DRIVE_GAIN_RESET = 8'd100;
  localparam logic [15:0] WET_MIX_RESET    = 16'd16384;
  localparam logic [15:0] WET_FULL         = 16'd32768;

  // Curve points are Q0.16, point zero is exactly 1.0 and needs a 17th bit
  localparam int CURVE_BITS = 17;

  // Elaboration-time unsigned quotient, restoring shift/subtract
  function automatic longint unsigned elab_udiv(longint unsigned num, int unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      q   = q << 1;
      if (rem >= 64'(den)) begin
        rem = rem - 64'(den);
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  // Per-step ratio exp(-step) in Q2.30 from the series through its 24th-order term; step is in Q.30
  function automatic longint unsigned curve_ratio(longint unsigned step);
    longint unsigned term;
    longint unsigned r;
    term = 64'd1 << 30;
    r    = term;
    for (int n = 1; n <= 24; n++) begin
      term = elab_udiv((term * step) >> 30, 32'(n));
      if ((n & 1) == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    return r;
  endfunction

endpackage

### rtl/core/exponential_soft_clip_distortion.sv
// Top level of the exponential soft-clip distortion with dry/wet mix.
`timescale 1ns / 1ps

// Exponential soft-clip distortion. Each signed Q1.F sample x is bent into
// z = sign(x) * (1 - exp(-drive_gain * |x|)) and mixed as
// wet_mix * z + (1 - wet_mix) * x, rounded and saturated to the sample range.
// The exponential comes from a constant ROM of CURVE_TABLE_ENTRIES points
// (exp(-16k/(N-1)) in Q0.16) with linear interpolation; the ROM is built at
// elaboration. Throughput is one sample per clock while out_stall_i is low;
// the datapath has seven stages (drive multiply, table scaling, ROM read,
// interpolation multiply, curve finish, mix multiplies, round/saturate).
// Every stage holds its own valid bit and only waits when the stage after it
// is full and waiting, so bubbles collapse under output stall and a new sample
// is taken while the output register still holds an untaken result.
// frame_end passes through with its sample. Registers: index 0 drive_gain
// (8 bits, reset 100), index 1 wet_mix (Q0.15, reset 16384, values above
// 32768 act as 32768); other indexes are ignored. Write configuration only
// while the pipeline is empty; cfg_ready_o is always high.
module exponential_soft_clip_distortion #(
  parameter int SAMPLE_BITS         = escd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int CURVE_TABLE_ENTRIES = escd_pkg::CURVE_TABLE_ENTRIES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [escd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [escd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // sample input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in_i,
  input  logic                                frame_end_in_i,
  // sample output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       sample_out_o,
  output logic                                frame_end_out_o
);

  localparam int SB      = SAMPLE_BITS;
  localparam int F       = SB - 1;             // fraction bits
  localparam int N       = CURVE_TABLE_ENTRIES;
  localparam int CB      = escd_pkg::CURVE_BITS;
  localparam int IDX_W   = $clog2(N);
  localparam int U_W     = 8 + SB;             // drive * |x|
  localparam int S_W     = U_W + IDX_W;        // scaled table position
  localparam int POS     = F + 4;              // fraction bits of the position
  localparam int SIDX_W  = S_W - POS;          // integer part of the position
  localparam int PROD_W  = CB + POS;           // delta * fraction
  localparam int ZF_W    = CB + F;
  localparam int MUL_W   = SB + 18;            // 17-bit mix * (SB+1)-bit sample
  localparam int ACC_W   = SB + 19;
  localparam int STAGES  = 7;

  localparam logic [SIDX_W-1:0] LastIdx  = SIDX_W'(N - 1);
  localparam logic [IDX_W-1:0]  LastAddr = IDX_W'(N - 1);
  localparam logic [S_W-1:0]    NScale   = S_W'(N - 1);

  localparam logic signed [ACC_W-1:0] MaxV     = ACC_W'((64'd1 << F) - 64'd1);
  localparam logic signed [ACC_W-1:0] MinV     = -ACC_W'(64'd1 << F);
  localparam logic signed [ACC_W-1:0] RoundQ15 = ACC_W'(16384);

  // Curve ROM: each word holds {point k, point k minus point k+1}
  localparam longint unsigned CurveStep  = (64'd16 << 30) / longint'(N - 1);
  localparam longint unsigned CurveRatio = escd_pkg::curve_ratio(CurveStep);

  typedef logic [2*CB-1:0] curve_tab_t [N];

  function automatic curve_tab_t build_curve();
    curve_tab_t      t;
    logic [CB-1:0]   pt [N];
    longint unsigned cur;
    cur = 64'd1 << 30;
    for (int k = 0; k < N; k++) begin
      pt[k] = CB'((cur + 64'd8192) >> 14);
      cur   = (cur * CurveRatio + (64'd1 << 29)) >> 30;
    end
    for (int k = 0; k < N; k++) begin
      if (k == N - 1) begin
        t[k] = {pt[k], CB'(0)};
      end else if (pt[k] >= pt[k+1]) begin
        t[k] = {pt[k], CB'(pt[k] - pt[k+1])};
      end else begin
        t[k] = {pt[k], CB'(0)};
      end
    end
    return t;
  endfunction

  localparam curve_tab_t CurveTab = build_curve();

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0]  drive_q;
  logic [15:0] wet_q;
  logic [15:0] wet_w;    // clamped wet share
  logic [15:0] dry_w;    // 1 - wet share

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q <= escd_pkg::DRIVE_GAIN_RESET;
      wet_q   <= escd_pkg::WET_MIX_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        escd_pkg::CFG_DRIVE_GAIN: drive_q <= cfg_data_i[7:0];
        escd_pkg::CFG_WET_MIX:    wet_q   <= cfg_data_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  assign wet_w = (wet_q > escd_pkg::WET_FULL) ? escd_pkg::WET_FULL : wet_q;
  assign dry_w = escd_pkg::WET_FULL - wet_w;

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage moves when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] adv;
  logic [STAGES-1:0] vld_d;

  always_comb begin
    adv[STAGES-1] = !vld_q[STAGES-1] || !out_stall_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = in_valid_i;
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (adv[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: magnitude and drive multiply
  // ---------------------------------------------------------------------------
  logic [SB-1:0]         mag;
  logic [U_W-1:0]        u1_q;
  logic signed [SB-1:0]  x1_q;
  logic                  fe1_q;

  assign mag = sample_in_i[SB-1] ? SB'(-sample_in_i) : SB'(sample_in_i);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      u1_q  <= U_W'(drive_q) * U_W'(mag);
      x1_q  <= sample_in_i;
      fe1_q <= frame_end_in_i;
    end
  end

  // Stage 2: scale to table position
  logic [S_W-1:0]        s2_q;
  logic signed [SB-1:0]  x2_q;
  logic                  fe2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_q  <= S_W'(u1_q) * NScale;
      x2_q  <= x1_q;
      fe2_q <= fe1_q;
    end
  end

  // Stage 3: ROM read; positions past the end read the last point, zero delta
  logic [SIDX_W-1:0]     sidx;
  logic [IDX_W-1:0]      addr;
  logic [2*CB-1:0]       ent3_q;
  logic [POS-1:0]        fr3_q;
  logic signed [SB-1:0]  x3_q;
  logic                  fe3_q;

  assign sidx = s2_q[S_W-1:POS];
  assign addr = (sidx >= LastIdx) ? LastAddr : sidx[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      ent3_q <= CurveTab[addr];
      fr3_q  <= s2_q[POS-1:0];
      x3_q   <= x2_q;
      fe3_q  <= fe2_q;
    end
  end

  // Stage 4: interpolation multiply
  logic [PROD_W-1:0]     prod4_q;
  logic [CB-1:0]         a4_q;
  logic signed [SB-1:0]  x4_q;
  logic                  fe4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      prod4_q <= PROD_W'(ent3_q[CB-1:0]) * PROD_W'(fr3_q);
      a4_q    <= ent3_q[2*CB-1:CB];
      x4_q    <= x3_q;
      fe4_q   <= fe3_q;
    end
  end

  // Stage 5: finish curve, z = sign(x) * round((1 - e) * 2^F)
  logic [CB-1:0]          e5;
  logic [CB-1:0]          one_minus_e;
  logic [ZF_W-1:0]        zfull;
  logic [F:0]             zmag;
  logic signed [SB:0]     z5_q;
  logic signed [SB-1:0]   x5_q;
  logic                   fe5_q;

  assign e5          = a4_q - prod4_q[PROD_W-1:POS];
  assign one_minus_e = CB'(65536) - e5;
  assign zfull       = {one_minus_e, F'(0)} + ZF_W'(32768);
  assign zmag        = zfull[ZF_W-1:16];

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      z5_q  <= x4_q[SB-1] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
      x5_q  <= x4_q;
      fe5_q <= fe4_q;
    end
  end

  // Stage 6: wet and dry products
  logic signed [MUL_W-1:0] pw6_q;
  logic signed [MUL_W-1:0] pd6_q;
  logic                    fe6_q;
  logic signed [SB:0]      x5_ext;

  assign x5_ext = {x5_q[SB-1], x5_q};

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      pw6_q <= $signed({1'b0, wet_w}) * z5_q;
      pd6_q <= $signed({1'b0, dry_w}) * x5_ext;
      fe6_q <= fe5_q;
    end
  end

  // Stage 7: sum, round half up in Q15, saturate; this is the output register
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] yfull;
  logic signed [SB-1:0]    ysat;
  logic signed [SB-1:0]    y7_q;
  logic                    fe7_q;

  always_comb begin
    acc   = ACC_W'(pw6_q) + ACC_W'(pd6_q);
    yfull = (acc + RoundQ15) >>> 15;
    if (yfull > MaxV) begin
      ysat = MaxV[SB-1:0];
    end else if (yfull < MinV) begin
      ysat = MinV[SB-1:0];
    end else begin
      ysat = yfull[SB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      y7_q  <= ysat;
      fe7_q <= fe6_q;
    end
  end

  assign out_valid_o     = vld_q[STAGES-1];
  assign sample_out_o    = y7_q;
  assign frame_end_out_o = fe7_q;

endmodule
